// File: rtl/kvt_pkg.sv
package kvt_pkg;

  // Fixed field widths of the channels
  localparam int OPCODE_W = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Default sizing of the table
  localparam int CAPACITY_DEF   = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET    = 2'd0,
    OP_GET    = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic    fire;
    opcode_t op;
    logic    hit;
  } kvt_ctrl_t;

endpackage

// File: rtl/kvt_if.sv
interface kvt_in_if import kvt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OPCODE_W-1:0] opcode;
  logic [KEY_W-1:0]    lookup_key;
  logic [VALUE_W-1:0]  write_value;

  modport source (output valid, opcode, lookup_key, write_value, input ready);
  modport sink   (input valid, opcode, lookup_key, write_value, output ready);
endinterface

interface kvt_out_if import kvt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  read_value;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

// File: rtl/kvt_cell.sv
module kvt_cell import kvt_pkg::*; #(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int CW         = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  kvt_ctrl_t             ctrl,
  input  logic [CW-1:0]         count,
  input  logic [KEY_BITS-1:0]   cmd_key,
  input  logic [VALUE_BITS-1:0] cmd_value,
  input  logic                  prev_hit,
  input  logic [KEY_BITS-1:0]   up_key,
  input  logic [VALUE_BITS-1:0] up_value,
  output logic                  match,
  output logic                  hit_out,
  output logic [KEY_BITS-1:0]   stored_key,
  output logic [VALUE_BITS-1:0] stored_value
);

  logic                  occupied;
  logic                  is_tail;
  logic                  has_upper;
  logic [KEY_BITS-1:0]   key_next;
  logic [VALUE_BITS-1:0] value_next;

  // Compare against the command key when this slot holds an entry
  assign occupied  = CW'(IDX) < count;
  assign is_tail   = CW'(IDX) == count;
  assign has_upper = CW'(IDX + 1) < count;
  assign match     = occupied && (stored_key == cmd_key);
  assign hit_out   = prev_hit | match;

  // Update, append at the tail, or pull the upper neighbor down on delete
  always_comb begin
    key_next   = stored_key;
    value_next = stored_value;
    if (ctrl.fire) begin
      unique case (ctrl.op)
        OP_SET: begin
          if (match) begin
            value_next = cmd_value;
          end else if (!ctrl.hit && is_tail) begin
            key_next   = cmd_key;
            value_next = cmd_value;
          end
        end
        OP_DELETE: begin
          if (hit_out && has_upper) begin
            key_next   = up_key;
            value_next = up_value;
          end
        end
        OP_GET, OP_CLEAR: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    stored_key   <= key_next;
    stored_value <= value_next;
  end

endmodule

// File: rtl/compacting_key_value_table_unit.sv
// Sequence: the edge on which an item transfers captures the command; the
//   execute state, once the result register is free or being read, runs it
//   through the row of cells and loads the result register.
// Flow: an item is taken only after the last one executes. The execute cycle
//   does the parallel key compare in all cells and the one-slot neighbor shift
//   at once. A result waiting for ready holds it and the input until transfer.
// Reset: synchronous, clears the entry count, the controller and the result
//   register; the key and value cells are left undefined until written.
module compacting_key_value_table_unit import kvt_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  kvt_in_if.sink    item_in,
  kvt_out_if.source result_out
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int KIN = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VIN = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  state_t                state;
  state_t                state_next;
  opcode_t               cmd_op;
  logic [KEY_BITS-1:0]   cmd_key;
  logic [VALUE_BITS-1:0] cmd_value;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic                  fire;
  logic                  hit;
  kvt_ctrl_t             ctrl;
  status_t               res_status;
  logic [VALUE_BITS-1:0] hit_value;
  logic [VALUE_W-1:0]    res_value;

  logic [CAPACITY-1:0]   match_vec;
  logic [CAPACITY:0]     hit_chain;
  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];

  logic                  out_valid;
  status_t               out_status;
  logic [VALUE_W-1:0]    out_value;
  logic [COUNT_W-1:0]    out_count;

  // Controller: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (item_in.valid) state_next = ST_EXEC;
      ST_EXEC: if (!out_valid || result_out.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller: outputs
  always_comb begin
    item_in.ready = 1'b0;
    fire          = 1'b0;
    unique case (state)
      ST_IDLE: item_in.ready = 1'b1;
      ST_EXEC: fire = !out_valid || result_out.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the command on transfer, keeping only the used key and value bits
  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      cmd_op    <= opcode_t'(item_in.opcode);
      cmd_key   <= KEY_BITS'(item_in.lookup_key[KIN-1:0]);
      cmd_value <= VALUE_BITS'(item_in.write_value[VIN-1:0]);
    end
  end

  // Row of cells; the hit chain marks every slot at or above the matching one
  assign hit_chain[0] = 1'b0;
  assign ctrl.fire    = fire;
  assign ctrl.op      = cmd_op;
  assign ctrl.hit     = hit;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [KEY_BITS-1:0]   up_key;
    logic [VALUE_BITS-1:0] up_value;

    if (j + 1 < CAPACITY) begin : g_mid
      assign up_key   = cell_key[j+1];
      assign up_value = cell_value[j+1];
    end else begin : g_last
      assign up_key   = '0;
      assign up_value = '0;
    end

    kvt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .CW         (CW),
      .IDX        (j)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .count        (count),
      .cmd_key      (cmd_key),
      .cmd_value    (cmd_value),
      .prev_hit     (hit_chain[j]),
      .up_key       (up_key),
      .up_value     (up_value),
      .match        (match_vec[j]),
      .hit_out      (hit_chain[j+1]),
      .stored_key   (cell_key[j]),
      .stored_value (cell_value[j])
    );
  end

  assign hit = hit_chain[CAPACITY];

  // Keys are unique among valid slots, so an OR over matches selects the value
  always_comb begin
    hit_value = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      hit_value = hit_value | (match_vec[j] ? cell_value[j] : '0);
    end
  end

  // Result and new entry count
  always_comb begin
    count_next = count;
    res_status = STATUS_DONE;
    res_value  = '0;
    unique case (cmd_op)
      OP_SET: begin
        if (!hit) begin
          if (count < CW'(CAPACITY)) begin
            count_next = count + CW'(1);
          end else begin
            res_status = STATUS_FULL;
          end
        end
      end
      OP_GET: begin
        if (hit) begin
          res_value = VALUE_W'(hit_value);
        end else begin
          res_status = STATUS_MISS;
        end
      end
      OP_DELETE: begin
        if (hit) begin
          count_next = count - CW'(1);
        end else begin
          res_status = STATUS_MISS;
        end
      end
      OP_CLEAR: count_next = '0;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // Result register: load on execute, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_count  <= COUNT_W'(count_next);
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.status      = out_status;
  assign result_out.read_value  = out_value;
  assign result_out.entry_count = out_count;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |-> $onehot0(match_vec))
    else $error("key present in more than one slot");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    fire && cmd_op == OP_CLEAR |=> count == '0)
    else $error("clear left entries behind");

  a_full_report: assert property (@(posedge clk) disable iff (rst)
    fire && cmd_op == OP_SET && !hit && count == CW'(CAPACITY)
    |=> result_out.status == STATUS_FULL && $stable(count))
    else $error("set into full table not reported");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_out.valid)
    else $error("executed item produced no result");

endmodule
